### rtl/sm4_cbc_encrypt_defines.svh
// ----------------------------------------------------------------------------
// SM4 CBC encryptor: assertion macros
// Shared forms for the concurrent checks in the RTL. They expect clk and arst_n
// in scope.
// ----------------------------------------------------------------------------
`ifndef SM4_CBC_ENCRYPT_DEFINES_SVH
`define SM4_CBC_ENCRYPT_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SM4_ASSERT_SAME(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("sm4 check failed: same-cycle rule");

// The consequent must hold in the cycle after the antecedent.
`define SM4_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("sm4 check failed: next-cycle rule");

`endif

### rtl/sm4_pkg.sv
// ----------------------------------------------------------------------------
// SM4 CBC encryptor package
// Constants, S-box, round functions and the types shared by controller and
// datapath.
// ----------------------------------------------------------------------------
package sm4_pkg;

	localparam int ROUND_COUNT = 32;
	localparam int RK_IDX_W    = $clog2(ROUND_COUNT);
	localparam logic [RK_IDX_W-1:0] LAST_ROUND = RK_IDX_W'(ROUND_COUNT - 1);

	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] CFG_KEY_HIGH = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_KEY_LOW  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_IV_HIGH  = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_IV_LOW   = 2'd3;

	localparam logic [63:0] KEY_HIGH_RST = 64'h0123_4567_89ab_cdef;
	localparam logic [63:0] KEY_LOW_RST  = 64'hfedc_ba98_7654_3210;

	localparam logic [127:0] FK = 128'ha3b1bac6_56aa3350_677d9197_b27022dc;

	localparam logic [7:0] SBOX [256] = '{
		8'hd6,8'h90,8'he9,8'hfe,8'hcc,8'he1,8'h3d,8'hb7,8'h16,8'hb6,8'h14,8'hc2,8'h28,8'hfb,8'h2c,8'h05,
		8'h2b,8'h67,8'h9a,8'h76,8'h2a,8'hbe,8'h04,8'hc3,8'haa,8'h44,8'h13,8'h26,8'h49,8'h86,8'h06,8'h99,
		8'h9c,8'h42,8'h50,8'hf4,8'h91,8'hef,8'h98,8'h7a,8'h33,8'h54,8'h0b,8'h43,8'hed,8'hcf,8'hac,8'h62,
		8'he4,8'hb3,8'h1c,8'ha9,8'hc9,8'h08,8'he8,8'h95,8'h80,8'hdf,8'h94,8'hfa,8'h75,8'h8f,8'h3f,8'ha6,
		8'h47,8'h07,8'ha7,8'hfc,8'hf3,8'h73,8'h17,8'hba,8'h83,8'h59,8'h3c,8'h19,8'he6,8'h85,8'h4f,8'ha8,
		8'h68,8'h6b,8'h81,8'hb2,8'h71,8'h64,8'hda,8'h8b,8'hf8,8'heb,8'h0f,8'h4b,8'h70,8'h56,8'h9d,8'h35,
		8'h1e,8'h24,8'h0e,8'h5e,8'h63,8'h58,8'hd1,8'ha2,8'h25,8'h22,8'h7c,8'h3b,8'h01,8'h21,8'h78,8'h87,
		8'hd4,8'h00,8'h46,8'h57,8'h9f,8'hd3,8'h27,8'h52,8'h4c,8'h36,8'h02,8'he7,8'ha0,8'hc4,8'hc8,8'h9e,
		8'hea,8'hbf,8'h8a,8'hd2,8'h40,8'hc7,8'h38,8'hb5,8'ha3,8'hf7,8'hf2,8'hce,8'hf9,8'h61,8'h15,8'ha1,
		8'he0,8'hae,8'h5d,8'ha4,8'h9b,8'h34,8'h1a,8'h55,8'had,8'h93,8'h32,8'h30,8'hf5,8'h8c,8'hb1,8'he3,
		8'h1d,8'hf6,8'he2,8'h2e,8'h82,8'h66,8'hca,8'h60,8'hc0,8'h29,8'h23,8'hab,8'h0d,8'h53,8'h4e,8'h6f,
		8'hd5,8'hdb,8'h37,8'h45,8'hde,8'hfd,8'h8e,8'h2f,8'h03,8'hff,8'h6a,8'h72,8'h6d,8'h6c,8'h5b,8'h51,
		8'h8d,8'h1b,8'haf,8'h92,8'hbb,8'hdd,8'hbc,8'h7f,8'h11,8'hd9,8'h5c,8'h41,8'h1f,8'h10,8'h5a,8'hd8,
		8'h0a,8'hc1,8'h31,8'h88,8'ha5,8'hcd,8'h7b,8'hbd,8'h2d,8'h74,8'hd0,8'h12,8'hb8,8'he5,8'hb4,8'hb0,
		8'h89,8'h69,8'h97,8'h4a,8'h0c,8'h96,8'h77,8'h7e,8'h65,8'hb9,8'hf1,8'h09,8'hc5,8'h6e,8'hc6,8'h84,
		8'h18,8'hf0,8'h7d,8'hec,8'h3a,8'hdc,8'h4d,8'h20,8'h79,8'hee,8'h5f,8'h3e,8'hd7,8'hcb,8'h39,8'h48
	};

	typedef enum logic [2:0] {
		ST_IDLE    = 3'b001,
		ST_EXPAND  = 3'b010,
		ST_ENCRYPT = 3'b100
	} state_t;

	typedef struct packed {
		logic                load;
		logic                start;
		logic                exp_en;
		logic                enc_en;
		logic                finish;
		logic [RK_IDX_W-1:0] idx;
		logic [RK_IDX_W-1:0] rd_idx;
	} ctrl_cmd_t;

	function automatic logic [31:0] rotl(input logic [31:0] v, input int n);
		return (v << n) | (v >> (32 - n));
	endfunction

	function automatic logic [31:0] tau(input logic [31:0] a);
		return {SBOX[a[31:24]], SBOX[a[23:16]], SBOX[a[15:8]], SBOX[a[7:0]]};
	endfunction

	function automatic logic [31:0] l_enc(input logic [31:0] b);
		return b ^ rotl(b, 2) ^ rotl(b, 10) ^ rotl(b, 18) ^ rotl(b, 24);
	endfunction

	function automatic logic [31:0] l_key(input logic [31:0] b);
		return b ^ rotl(b, 13) ^ rotl(b, 23);
	endfunction

	// Byte j of CK[i] is (4i + j) * 7 modulo 256, formed as 8x - x.
	function automatic logic [31:0] ck_word(input logic [RK_IDX_W-1:0] i);
		logic [31:0] w;
		logic [7:0]  x;
		w = '0;
		for (int j = 0; j < 4; j++) begin
			x = 8'({i, 2'(j)});
			w = {w[23:0], 8'((x << 3) - x)};
		end
		return w;
	endfunction

endpackage

### rtl/sm4_in_if.sv
// ----------------------------------------------------------------------------
// SM4 plaintext channel
// Valid/ready channel carrying one plaintext block and its restart flag.
// ----------------------------------------------------------------------------
interface sm4_in_if;
	logic        valid;
	logic        ready;
	logic [63:0] plain_high;
	logic [63:0] plain_low;
	logic        restart;

	modport source (output valid, output plain_high, output plain_low, output restart,
		input ready);
	modport sink (input valid, input plain_high, input plain_low, input restart,
		output ready);
endinterface

### rtl/sm4_out_if.sv
// ----------------------------------------------------------------------------
// SM4 ciphertext channel
// Valid/ready channel carrying one ciphertext block.
// ----------------------------------------------------------------------------
interface sm4_out_if;
	logic        valid;
	logic        ready;
	logic [63:0] cipher_high;
	logic [63:0] cipher_low;

	modport source (output valid, output cipher_high, output cipher_low, input ready);
	modport sink (input valid, input cipher_high, input cipher_low, output ready);
endinterface

### rtl/sm4_ram.sv
// ----------------------------------------------------------------------------
// SM4 generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module sm4_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

### rtl/sm4_datapath.sv
// ----------------------------------------------------------------------------
// SM4 datapath
// Configuration registers, chaining value, key schedule state, block state,
// the shared round unit, the round key store and the result register.
// ----------------------------------------------------------------------------
module sm4_datapath (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [sm4_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [63:0]                    cfg_data,
	input  sm4_pkg::ctrl_cmd_t             cmd,
	input  logic [63:0]                    plain_high,
	input  logic [63:0]                    plain_low,
	output logic [63:0]                    cipher_high,
	output logic [63:0]                    cipher_low
);

	logic [63:0]  key_high_q, key_low_q, iv_high_q, iv_low_q;
	logic [127:0] chain_q;
	logic [127:0] key_st_q;
	logic [127:0] work_q;
	logic [127:0] cipher_q;
	logic [127:0] chain_sel;
	logic [31:0]  rk_rd;
	logic [31:0]  mix_in;
	logic [31:0]  sub;
	logic [31:0]  new_key;
	logic [31:0]  new_word;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_high_q <= sm4_pkg::KEY_HIGH_RST;
			key_low_q  <= sm4_pkg::KEY_LOW_RST;
			iv_high_q  <= '0;
			iv_low_q   <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				sm4_pkg::CFG_KEY_HIGH: key_high_q <= cfg_data;
				sm4_pkg::CFG_KEY_LOW:  key_low_q  <= cfg_data;
				sm4_pkg::CFG_IV_HIGH:  iv_high_q  <= cfg_data;
				sm4_pkg::CFG_IV_LOW:   iv_low_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	assign chain_sel = cmd.start ? {iv_high_q, iv_low_q} : chain_q;

	// One S-box layer serves both the key schedule and the cipher rounds.
	assign mix_in = cmd.exp_en
		? (key_st_q[95:64] ^ key_st_q[63:32] ^ key_st_q[31:0] ^
			sm4_pkg::ck_word(cmd.idx))
		: (work_q[95:64] ^ work_q[63:32] ^ work_q[31:0] ^ rk_rd);
	assign sub      = sm4_pkg::tau(mix_in);
	assign new_key  = key_st_q[127:96] ^ sm4_pkg::l_key(sub);
	assign new_word = work_q[127:96] ^ sm4_pkg::l_enc(sub);

	sm4_ram #(
		.WIDTH(32),
		.DEPTH(sm4_pkg::ROUND_COUNT)
	) u_rk_ram (
		.clk  (clk),
		.we   (cmd.exp_en),
		.waddr(cmd.idx),
		.wdata(new_key),
		.raddr(cmd.rd_idx),
		.rdata(rk_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chain_q <= '0;
		end else if (cmd.finish) begin
			chain_q <= {new_word, work_q[31:0], work_q[63:32], work_q[95:64]};
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			work_q <= {plain_high, plain_low} ^ chain_sel;
		end else if (cmd.enc_en) begin
			work_q <= {work_q[95:0], new_word};
		end
		if (cmd.load && cmd.start) begin
			key_st_q <= {key_high_q, key_low_q} ^ sm4_pkg::FK;
		end else if (cmd.exp_en) begin
			key_st_q <= {key_st_q[95:0], new_key};
		end
		// The final round's output word order is reversed.
		if (cmd.finish) begin
			cipher_q <= {new_word, work_q[31:0], work_q[63:32], work_q[95:64]};
		end
	end

	assign cipher_high = cipher_q[127:64];
	assign cipher_low  = cipher_q[63:0];

endmodule

### rtl/sm4_ctrl.sv
// ----------------------------------------------------------------------------
// SM4 controller
// Sequences key expansion and cipher rounds and owns both handshakes.
// ----------------------------------------------------------------------------
`include "sm4_cbc_encrypt_defines.svh"

module sm4_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               in_restart,
	output logic               in_ready,
	output logic               out_valid,
	input  logic               out_ready,
	output sm4_pkg::ctrl_cmd_t cmd
);

	sm4_pkg::state_t                state_q, state_d;
	logic [sm4_pkg::RK_IDX_W-1:0]   cnt_q, cnt_d;
	logic                           keys_valid_q;
	logic                           out_valid_q;
	logic                           accept;
	logic                           start;
	logic                           last;
	logic                           out_free;
	logic                           finish;

	assign in_ready = (state_q == sm4_pkg::ST_IDLE);
	assign accept   = in_ready && in_valid;
	assign start    = in_restart || !keys_valid_q;
	assign last     = (cnt_q == sm4_pkg::LAST_ROUND);
	assign out_free = !out_valid_q || out_ready;
	assign finish   = (state_q == sm4_pkg::ST_ENCRYPT) && last && out_free;

	always_comb begin
		state_d = state_q;
		cnt_d   = cnt_q;
		case (state_q)
			sm4_pkg::ST_IDLE: begin
				if (accept) begin
					state_d = start ? sm4_pkg::ST_EXPAND : sm4_pkg::ST_ENCRYPT;
					cnt_d   = '0;
				end
			end
			sm4_pkg::ST_EXPAND: begin
				cnt_d = cnt_q + 1'b1;
				if (last) begin
					state_d = sm4_pkg::ST_ENCRYPT;
				end
			end
			sm4_pkg::ST_ENCRYPT: begin
				if (!last) begin
					cnt_d = cnt_q + 1'b1;
				end else if (out_free) begin
					state_d = sm4_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = sm4_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= sm4_pkg::ST_IDLE;
			cnt_q        <= '0;
			keys_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			if (accept && start) begin
				keys_valid_q <= 1'b1;
			end
			if (finish) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

	// The key store read is registered, so the next round's key is addressed during
	// the current round; on the last round the address holds while the result stalls.
	always_comb begin
		cmd.load   = accept;
		cmd.start  = start;
		cmd.exp_en = (state_q == sm4_pkg::ST_EXPAND);
		cmd.enc_en = (state_q == sm4_pkg::ST_ENCRYPT) && (!last || out_free);
		cmd.finish = finish;
		cmd.idx    = cnt_q;
		cmd.rd_idx = '0;
		if (state_q == sm4_pkg::ST_ENCRYPT) begin
			cmd.rd_idx = last ? cnt_q : cnt_q + 1'b1;
		end
	end

	`SM4_ASSERT_SAME(a_finish_no_overwrite, finish && out_valid_q, out_ready)
	`SM4_ASSERT_NEXT(a_start_expands, accept && start,
		state_q == sm4_pkg::ST_EXPAND && cnt_q == '0)
	`SM4_ASSERT_NEXT(a_resume_encrypts, accept && !start,
		state_q == sm4_pkg::ST_ENCRYPT && cnt_q == '0)
	`SM4_ASSERT_NEXT(a_expand_to_encrypt, state_q == sm4_pkg::ST_EXPAND && last,
		state_q == sm4_pkg::ST_ENCRYPT && cnt_q == '0 && keys_valid_q)

endmodule

### rtl/sm4_cbc_encrypt.sv
// ----------------------------------------------------------------------------
// SM4 CBC encryptor, top level
// Enciphers 128-bit blocks with SM4 in CBC mode, key and IV from configuration.
// ----------------------------------------------------------------------------
// After acceptance, one round is done per cycle by a single shared round unit,
// which holds on the last cipher round while the output register is still full.
// For the first block after reset, or one that carries restart, the 32 round
// keys are expanded first. The first round key is fetched from the store in the
// cycle the beat is accepted, or in the last expansion cycle when keys are expanded.
// A new plaintext beat is taken in the cycle after the ciphertext is registered,
// and the ciphertext may still wait in the output register by then.
// Key and IV writes take effect at the next restart and should only be made
// while the block is idle.
module sm4_cbc_encrypt (
	input  logic                          clk,
	input  logic                          arst_n,
	sm4_in_if.sink                        in_ch,
	sm4_out_if.source                     out_ch,
	input  logic                          cfg_we,
	input  logic [sm4_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [63:0]                   cfg_data
);

	sm4_pkg::ctrl_cmd_t cmd;
	logic               in_ready;
	logic               out_valid;
	logic [63:0]        cipher_high;
	logic [63:0]        cipher_low;

	sm4_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_ch.valid),
		.in_restart(in_ch.restart),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ch.ready),
		.cmd       (cmd)
	);

	sm4_datapath u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.cmd        (cmd),
		.plain_high (in_ch.plain_high),
		.plain_low  (in_ch.plain_low),
		.cipher_high(cipher_high),
		.cipher_low (cipher_low)
	);

	assign in_ch.ready        = in_ready;
	assign out_ch.valid       = out_valid;
	assign out_ch.cipher_high = cipher_high;
	assign out_ch.cipher_low  = cipher_low;

endmodule
